### rtl/core/jse_pkg.sv
// Shared types and constants for the JSON string escaper / UTF-8 encoder.
// No dependencies.
package jse_pkg;

  localparam int CpWidth   = 21;
  localparam int ByteWidth = 8;
  localparam int MaxBytes  = 6;
  localparam int IdxWidth  = $clog2(MaxBytes);

  // default depth of the queue between classifier and serializer
  localparam int QueueDepthDef = 2;

  localparam logic [ByteWidth-1:0] ChBackslash = 8'h5C;
  localparam logic [ByteWidth-1:0] ChQuote     = 8'h22;
  localparam logic [ByteWidth-1:0] ChLowB      = 8'h62;
  localparam logic [ByteWidth-1:0] ChLowF      = 8'h66;
  localparam logic [ByteWidth-1:0] ChLowN      = 8'h6E;
  localparam logic [ByteWidth-1:0] ChLowT      = 8'h74;
  localparam logic [ByteWidth-1:0] ChLowU      = 8'h75;
  localparam logic [ByteWidth-1:0] ChZero      = 8'h30;
  localparam logic [ByteWidth-1:0] ChLowA      = 8'h61;

  localparam logic [CpWidth-1:0] CpBackspace = 21'h08;
  localparam logic [CpWidth-1:0] CpTab       = 21'h09;
  localparam logic [CpWidth-1:0] CpNewline   = 21'h0A;
  localparam logic [CpWidth-1:0] CpFormFeed  = 21'h0C;
  localparam logic [CpWidth-1:0] CpQuote     = 21'h22;
  localparam logic [CpWidth-1:0] CpBackslash = 21'h5C;
  localparam logic [CpWidth-1:0] CpCtrlEnd   = 21'h20;
  localparam logic [CpWidth-1:0] CpAsciiEnd  = 21'h80;
  localparam logic [CpWidth-1:0] Cp2ByteEnd  = 21'h800;
  localparam logic [CpWidth-1:0] Cp3ByteEnd  = 21'h10000;

  // one classified code point: output bytes in order plus index of the last
  typedef struct packed {
    logic [MaxBytes-1:0][ByteWidth-1:0] bytes;
    logic [IdxWidth-1:0]                last_idx;
  } seq_t;

endpackage

### rtl/core/jse_front.sv
// Front end: accepts code points, maps each to its escaped UTF-8 byte sequence.
// Uses jse_pkg.
module jse_front
  import jse_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CpWidth-1:0] in_cp,
  output logic               seq_valid,
  input  logic               seq_ready,
  output seq_t               seq
);

  logic valid_r, valid_nxt;
  seq_t seq_r;
  seq_t seq_nxt;

  function automatic logic [ByteWidth-1:0] hex_lower(input logic [3:0] nib);
    logic [ByteWidth-1:0] r;
    if (nib < 4'd10) r = ChZero + {4'd0, nib};
    else             r = ChLowA + {4'd0, nib} - 8'd10;
    return r;
  endfunction

  always_comb begin
    seq_nxt = '0;
    seq_nxt.bytes[0] = ChBackslash;
    priority if (in_cp == CpQuote || in_cp == CpBackslash) begin
      seq_nxt.bytes[1] = in_cp[ByteWidth-1:0];
      seq_nxt.last_idx = IdxWidth'(1);
    end else if (in_cp == CpBackspace) begin
      seq_nxt.bytes[1] = ChLowB;
      seq_nxt.last_idx = IdxWidth'(1);
    end else if (in_cp == CpFormFeed) begin
      seq_nxt.bytes[1] = ChLowF;
      seq_nxt.last_idx = IdxWidth'(1);
    end else if (in_cp == CpNewline) begin
      seq_nxt.bytes[1] = ChLowN;
      seq_nxt.last_idx = IdxWidth'(1);
    end else if (in_cp == CpTab) begin
      seq_nxt.bytes[1] = ChLowT;
      seq_nxt.last_idx = IdxWidth'(1);
    end else if (in_cp < CpCtrlEnd) begin
      // \u00xx, lowercase hex
      seq_nxt.bytes[1] = ChLowU;
      seq_nxt.bytes[2] = ChZero;
      seq_nxt.bytes[3] = ChZero;
      seq_nxt.bytes[4] = hex_lower(in_cp[7:4]);
      seq_nxt.bytes[5] = hex_lower(in_cp[3:0]);
      seq_nxt.last_idx = IdxWidth'(5);
    end else if (in_cp < CpAsciiEnd) begin
      seq_nxt.bytes[0] = in_cp[ByteWidth-1:0];
      seq_nxt.last_idx = IdxWidth'(0);
    end else if (in_cp < Cp2ByteEnd) begin
      seq_nxt.bytes[0] = {3'b110, in_cp[10:6]};
      seq_nxt.bytes[1] = {2'b10, in_cp[5:0]};
      seq_nxt.last_idx = IdxWidth'(1);
    end else if (in_cp < Cp3ByteEnd) begin
      seq_nxt.bytes[0] = {4'b1110, in_cp[15:12]};
      seq_nxt.bytes[1] = {2'b10, in_cp[11:6]};
      seq_nxt.bytes[2] = {2'b10, in_cp[5:0]};
      seq_nxt.last_idx = IdxWidth'(2);
    end else begin
      // surrogates handled above as plain 3-byte; >0x10FFFF uses same 4-byte form
      seq_nxt.bytes[0] = {5'b11110, in_cp[20:18]};
      seq_nxt.bytes[1] = {2'b10, in_cp[17:12]};
      seq_nxt.bytes[2] = {2'b10, in_cp[11:6]};
      seq_nxt.bytes[3] = {2'b10, in_cp[5:0]};
      seq_nxt.last_idx = IdxWidth'(3);
    end
  end

  assign in_ready  = !valid_r || seq_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      seq_r <= seq_nxt;
    end
  end

  assign seq_valid = valid_r;
  assign seq       = seq_r;

endmodule

### rtl/core/jse_queue.sv
// Small register queue of classified sequences between front and back.
// Uses jse_pkg.
module jse_queue
  import jse_pkg::*;
#(
  parameter int Depth = QueueDepthDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  seq_t push_data,
  output logic pop_valid,
  input  logic pop,
  output seq_t head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  seq_t mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign push_ready = (cnt_r != CntFull);
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + PtrW'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + PtrW'(1);
    if (do_push && !do_pop)      cnt_nxt = cnt_r + CntW'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CntW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/core/jse_back.sv
// Back end: walks the queue head one byte per cycle into an output register
// while out_ready does not stall it. Uses jse_pkg.
module jse_back
  import jse_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 seq_valid,
  output logic                 seq_pop,
  input  seq_t                 seq,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ByteWidth-1:0] out_byte,
  output logic                 out_last
);

  logic [IdxWidth-1:0]  idx_r, idx_nxt;
  logic                 valid_r, valid_nxt;
  logic [ByteWidth-1:0] byte_r;
  logic                 last_r;
  logic                 advance, emit, at_last;

  assign advance = !valid_r || out_ready;
  assign emit    = advance && seq_valid;
  assign at_last = (idx_r == seq.last_idx);
  assign seq_pop = emit && at_last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (advance) valid_nxt = seq_valid;
    if (emit)    idx_nxt   = at_last ? '0 : idx_r + IdxWidth'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r <= seq.bytes[idx_r];
      last_r <= at_last;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

endmodule

### rtl/core/json_string_escape_utf8_core.sv
// Top level of the JSON string escaper with UTF-8 encoding.
// Uses jse_pkg, jse_front, jse_queue, jse_back.
//
// Takes one code point per input beat and sends the bytes that stand for it
// inside a JSON string literal, one byte per output beat, with tlast on the
// final byte of each code point. Quote and backslash get a backslash prefix;
// backspace, form feed, newline and tab become \b \f \n \t; other controls
// below 0x20 become \u00xx in lowercase hex; the slash passes unchanged;
// everything else is UTF-8 encoded in 1 to 4 bytes (surrogates as plain
// 3-byte values, values above 0x10FFFF with the same 4-byte pattern, no
// error flagged). The output register moves one byte per cycle unless
// out_tready stalls it; a code point has 1 to 6 bytes, and a stream of
// 1-byte characters runs at one beat per cycle unless stalled. Input beats
// are taken every cycle while the classifier register and the queue
// (QueueDepth entries) have room. Data passes the classifier register,
// the queue and the output register. No state is kept between code points.
module json_string_escape_utf8_core
  import jse_pkg::*;
#(
  parameter int QueueDepth = QueueDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [20:0] code_point, [23:21] zero
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast   // last_byte
);

  // front -> queue
  logic f_valid, f_ready;
  seq_t f_seq;
  // queue -> back
  logic q_valid, q_pop;
  seq_t q_head;

  jse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cp     (in_tdata[CpWidth-1:0]),
    .seq_valid (f_valid),
    .seq_ready (f_ready),
    .seq       (f_seq)
  );

  jse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_seq),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .head       (q_head)
  );

  jse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .seq_valid (q_valid),
    .seq_pop   (q_pop),
    .seq       (q_head),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule
